/* rtl/rsam_pkg.sv */
// Package: shared types and constants of the RAID stripe address mapper.
`timescale 1ns / 1ps

package rsam_pkg;

    // RAID level codes
    typedef enum logic [1:0] {
        LVL_STRIPE = 2'd0,
        LVL_MIRROR = 2'd1,
        LVL_PARITY = 2'd2,
        LVL_PAIRS  = 2'd3
    } raid_level_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_RAID_LEVEL = 2'd0;
    localparam logic [1:0] CFG_CHUNK_LEN  = 2'd1;
    localparam logic [1:0] CFG_DATA_DISKS = 2'd2;

    // Field widths
    localparam int unsigned CHUNK_W     = 16;
    localparam int unsigned DISKS_W     = 4;
    localparam int unsigned DISKS_P1_W  = 5;
    localparam int unsigned IN_SECT_W   = 48;
    localparam int unsigned OUT_SECT_W  = 48;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 56;

    // Reset values of the configuration registers
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 16'd128;
    localparam logic [DISKS_W-1:0] DISKS_RESET = 4'd2;

endpackage

/* rtl/raid_stripe_address_mapper_top.sv */
// Top level of the RAID stripe address mapper.
`timescale 1ns / 1ps
//
// Maps one logical sector per transaction to a member disk and a sector on it.
// Input stream s_*: tdata carries logical_sector. Output stream m_*: tdata
// carries disk_index, disk_sector and parity_index, tuser carries config_error.
// Configuration is to be written by the user through cfg_we/cfg_index/cfg_data
// only while no transaction is in flight; the block does not enforce this.
// Indexes: 0 raid_level, 1 chunk_len, 2 data_disk_count. Transactions pass, one
// per cycle while the receiver does not stall, through three rows of one-bit
// division cells (sector by chunk size, chunk by disk or pair count, row by disk
// count and by disk count plus one, the last two side by side), a multiply stage
// and the output register. Reset empties the pipeline and loads the registers
// with striping, 128 sectors per chunk and two data disks. When the receiver
// stalls the whole pipeline holds and s_tready falls; it rises again once the
// output is taken.
module raid_stripe_address_mapper_top #(
    parameter int unsigned DISK_SLOTS  = 16,
    parameter int unsigned SECTOR_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // [47:0] logical_sector
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // [3:0] disk_index, [51:4] disk_sector, [55:52] parity_index
    output logic        m_tuser   // [0] config_error
);

    localparam int unsigned SB = SECTOR_BITS;
    localparam int unsigned CW = rsam_pkg::CHUNK_W;
    localparam int unsigned NW = rsam_pkg::DISKS_W;
    localparam int unsigned PW = rsam_pkg::DISKS_P1_W;

    // Configuration registers
    rsam_pkg::raid_level_t level_reg;
    logic [CW-1:0]         chunk_reg;
    logic [NW-1:0]         disks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= rsam_pkg::LVL_STRIPE;
            chunk_reg <= rsam_pkg::CHUNK_RESET;
            disks_reg <= rsam_pkg::DISKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsam_pkg::CFG_RAID_LEVEL: level_reg <= rsam_pkg::raid_level_t'(cfg_data[1:0]);
                rsam_pkg::CFG_CHUNK_LEN:  chunk_reg <= cfg_data[CW-1:0];
                rsam_pkg::CFG_DATA_DISKS: disks_reg <= cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    // Divisors; mirroring passes the sector through with unit divisors
    logic          mirror;
    logic [CW-1:0] div_a;
    logic [NW-1:0] div_b;
    logic [PW-1:0] div_c;

    assign mirror = (level_reg == rsam_pkg::LVL_MIRROR);
    assign div_a  = mirror ? CW'(1) : chunk_reg;
    assign div_c  = {1'b0, disks_reg} + PW'(1);

    always_comb
    begin
        case (level_reg)
            rsam_pkg::LVL_MIRROR: div_b = NW'(1);
            rsam_pkg::LVL_PAIRS:  div_b = disks_reg >> 1;
            default:              div_b = disks_reg;
        endcase
    end

    // Whole pipeline advances whenever the output register is empty or being taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [63:0] in_wide;
    assign in_wide = 64'(s_tdata);

    // Sector / chunk size
    logic          a_valid;
    logic [SB-1:0] a_chunk;
    logic [CW-1:0] a_off;

    rsam_div_chain #(.QW(SB), .DW(CW), .SW(1)) u_div_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .divisor    (div_a),
        .in_valid   (s_tvalid),
        .in_dividend(in_wide[SB-1:0]),
        .in_side    (1'b0),
        .out_valid  (a_valid),
        .out_quot   (a_chunk),
        .out_rem    (a_off),
        .out_side   ()
    );

    // Chunk / disk count (or pair count)
    logic          b_valid;
    logic [SB-1:0] b_row;
    logic [NW-1:0] b_d;
    logic [CW-1:0] b_off;

    rsam_div_chain #(.QW(SB), .DW(NW), .SW(CW)) u_div_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .divisor    (div_b),
        .in_valid   (a_valid),
        .in_dividend(a_chunk),
        .in_side    (a_off),
        .out_valid  (b_valid),
        .out_quot   (b_row),
        .out_rem    (b_d),
        .out_side   (b_off)
    );

    // Row modulo n+1 and row modulo n, side by side
    localparam int unsigned CSW = SB + NW + CW;

    logic           c_valid;
    logic [PW-1:0]  c_mod1;
    logic [NW-1:0]  c_mod0;
    logic [CSW-1:0] c_side;
    logic [SB-1:0]  c_row;
    logic [NW-1:0]  c_d;
    logic [CW-1:0]  c_off;

    rsam_div_chain #(.QW(SB), .DW(PW), .SW(CSW)) u_div_c1 (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .divisor    (div_c),
        .in_valid   (b_valid),
        .in_dividend(b_row),
        .in_side    ({b_off, b_d, b_row}),
        .out_valid  (c_valid),
        .out_quot   (),
        .out_rem    (c_mod1),
        .out_side   (c_side)
    );

    rsam_div_chain #(.QW(SB), .DW(NW), .SW(1)) u_div_c0 (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .divisor    (disks_reg),
        .in_valid   (b_valid),
        .in_dividend(b_row),
        .in_side    (1'b0),
        .out_valid  (),
        .out_quot   (),
        .out_rem    (c_mod0),
        .out_side   ()
    );

    assign c_row = c_side[SB-1:0];
    assign c_d   = c_side[SB+NW-1:SB];
    assign c_off = c_side[CSW-1:SB+NW];

    // Parity disk and data disk
    logic [PW:0]   p_sum;
    logic [PW:0]   p_sub;
    logic [NW-1:0] p_disk;
    logic [NW-1:0] disk_sel;

    always_comb
    begin
        p_sum  = {1'b0, c_mod1} + {2'b00, c_mod0};
        p_sub  = p_sum - {1'b0, div_c};
        p_disk = (p_sum >= {1'b0, div_c}) ? p_sub[NW-1:0] : p_sum[NW-1:0];
        case (level_reg)
            rsam_pkg::LVL_PARITY: disk_sel = (c_d < p_disk) ? c_d : c_d + NW'(1);
            rsam_pkg::LVL_PAIRS:  disk_sel = {c_d[NW-2:0], 1'b0};
            default:              disk_sel = c_d;
        endcase
    end

    // Multiply stage: row times chunk size
    logic               m1_valid_reg;
    logic [SB-1:0]      m1_prod_reg;
    logic [CW-1:0]      m1_off_reg;
    logic [NW-1:0]      m1_disk_reg;
    logic [NW-1:0]      m1_par_reg;
    logic [SB+CW-1:0]   prod_full;

    assign prod_full = c_row * div_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_prod_reg <= prod_full[SB-1:0];
            m1_off_reg  <= c_off;
            m1_disk_reg <= disk_sel;
            m1_par_reg  <= (level_reg == rsam_pkg::LVL_PARITY) ? p_disk : '0;
        end
    end

    // Configuration check
    logic cfg_err;
    always_comb
    begin
        case (level_reg)
            rsam_pkg::LVL_MIRROR: cfg_err = 1'b0;
            rsam_pkg::LVL_STRIPE:
                cfg_err = (chunk_reg == '0) || (disks_reg == '0)
                          || (32'(disks_reg) > DISK_SLOTS);
            rsam_pkg::LVL_PARITY:
                cfg_err = (chunk_reg == '0) || (disks_reg == '0)
                          || (32'(disks_reg) + 32'd1 > DISK_SLOTS);
            default:
                cfg_err = (chunk_reg == '0) || (disks_reg < NW'(2))
                          || (32'(disks_reg) > DISK_SLOTS);
        endcase
    end

    // Final add and output register
    logic [SB-1:0] sect_sum;
    logic [63:0]   sect_wide;

    assign sect_sum  = m1_prod_reg + SB'(m1_off_reg);
    assign sect_wide = 64'(sect_sum);

    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic        out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_err_reg <= cfg_err;
            if (cfg_err)
            begin
                out_data_reg <= '0;
            end
            else
            begin
                out_data_reg <= {m1_par_reg, sect_wide[rsam_pkg::OUT_SECT_W-1:0], m1_disk_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

endmodule

/* rtl/rsam_cell.sv */
// One restoring-division cell: one quotient bit per cell, plus sideband payload.
`timescale 1ns / 1ps

module rsam_cell #(
    parameter int unsigned QW = 48,
    parameter int unsigned DW = 16,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [DW-1:0] divisor,
    input  logic          in_valid,
    input  logic [QW-1:0] in_x,
    input  logic [DW-1:0] in_r,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_x,
    output logic [DW-1:0] out_r,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [QW-1:0] x_reg, x_next;
    logic [DW-1:0] r_reg, r_next;
    logic [SW-1:0] side_reg;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb
    begin
        logic [DW:0] t;
        logic [DW:0] diff;
        logic        ge;
        t      = {in_r, in_x[QW-1]};
        diff   = t - {1'b0, divisor};
        ge     = (t >= {1'b0, divisor});
        r_next = ge ? diff[DW-1:0] : t[DW-1:0];
        x_next = {in_x[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            r_reg    <= r_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_r     = r_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/rsam_div_chain.sv */
// Row of division cells: QW cells give quotient and remainder of x / divisor.
`timescale 1ns / 1ps

module rsam_div_chain #(
    parameter int unsigned QW = 48,
    parameter int unsigned DW = 16,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [DW-1:0] divisor,
    input  logic          in_valid,
    input  logic [QW-1:0] in_dividend,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quot,
    output logic [DW-1:0] out_rem,
    output logic [SW-1:0] out_side
);

    logic          v [0:QW];
    logic [QW-1:0] x [0:QW];
    logic [DW-1:0] r [0:QW];
    logic [SW-1:0] s [0:QW];

    assign v[0] = in_valid;
    assign x[0] = in_dividend;
    assign r[0] = '0;
    assign s[0] = in_side;

    // One cell per quotient bit, most significant first
    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        rsam_cell #(
            .QW(QW),
            .DW(DW),
            .SW(SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .divisor  (divisor),
            .in_valid (v[i]),
            .in_x     (x[i]),
            .in_r     (r[i]),
            .in_side  (s[i]),
            .out_valid(v[i+1]),
            .out_x    (x[i+1]),
            .out_r    (r[i+1]),
            .out_side (s[i+1])
        );
    end

    assign out_valid = v[QW];
    assign out_quot  = x[QW];
    assign out_rem   = r[QW];
    assign out_side  = s[QW];

endmodule

/* dv/rsam_checker.sv */
// Checker of the RAID stripe address mapper: predicts each mapping and compares results.
`timescale 1ns / 1ps

module rsam_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [3:0]  disk_index;
        logic [47:0] disk_sector;
        logic [3:0]  parity_index;
        logic        config_error;
    } mapping_t;

    rsam_pkg::raid_level_t level_q;
    logic [15:0]           chunk_q;
    logic [3:0]            disks_q;
    mapping_t              mapping_q[$];

    // Work out where one logical sector lands under the current settings
    function automatic mapping_t map_sector(logic [47:0] sect);
        mapping_t    r;
        logic [63:0] n, cs, chunk, offs, row, p, d;
        r = '0;
        n = 64'(disks_q);
        cs = 64'(chunk_q);
        if (level_q == rsam_pkg::LVL_MIRROR)
        begin
            r.disk_sector = sect;
            return r;
        end
        if (cs == 0 || n == 0)
        begin
            r.config_error = 1'b1;
            return r;
        end
        chunk = 64'(sect) / cs;
        offs = 64'(sect) % cs;
        case (level_q)
            rsam_pkg::LVL_STRIPE:
            begin
                r.disk_index = 4'(chunk % n);
                r.disk_sector = 48'((chunk / n) * cs + offs);
            end
            rsam_pkg::LVL_PARITY:
            begin
                if (n + 1 > 16)
                begin
                    r.config_error = 1'b1;
                    return r;
                end
                row = chunk / n;
                p = (row % (n + 1) + row % n) % (n + 1);
                d = chunk % n;
                r.disk_index = 4'((d < p) ? d : d + 1);
                r.disk_sector = 48'(row * cs + offs);
                r.parity_index = 4'(p);
            end
            default:
            begin
                if (n < 2)
                begin
                    r.config_error = 1'b1;
                    return r;
                end
                r.disk_index = 4'((chunk % (n / 2)) * 2);
                r.disk_sector = 48'((chunk / (n / 2)) * cs + offs);
            end
        endcase
        return r;
    endfunction

    // Track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        mapping_t e;
        int       errs;
        if (!rst_n)
        begin
            level_q <= rsam_pkg::LVL_STRIPE;
            chunk_q <= rsam_pkg::CHUNK_RESET;
            disks_q <= rsam_pkg::DISKS_RESET;
            fail_count <= 0;
            pending <= 0;
            mapping_q.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                if (cfg_index == rsam_pkg::CFG_RAID_LEVEL)
                    level_q <= rsam_pkg::raid_level_t'(cfg_data[1:0]);
                else if (cfg_index == rsam_pkg::CFG_CHUNK_LEN)
                    chunk_q <= cfg_data;
                else if (cfg_index == rsam_pkg::CFG_DATA_DISKS)
                    disks_q <= cfg_data[3:0];
            end
            if (s_tvalid && s_tready)
                mapping_q.push_back(map_sector(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (mapping_q.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errs++;
                end
                else
                begin
                    e = mapping_q.pop_front();
                    if (m_tdata[3:0] !== e.disk_index)
                    begin
                        $error("disk_index exp %0d got %0d", e.disk_index, m_tdata[3:0]);
                        errs++;
                    end
                    if (m_tdata[51:4] !== e.disk_sector)
                    begin
                        $error("disk_sector exp %0h got %0h", e.disk_sector, m_tdata[51:4]);
                        errs++;
                    end
                    if (m_tdata[55:52] !== e.parity_index)
                    begin
                        $error("parity_index exp %0d got %0d", e.parity_index,
                               m_tdata[55:52]);
                        errs++;
                    end
                    if (m_tuser !== e.config_error)
                    begin
                        $error("config_error exp %0b got %0b", e.config_error, m_tuser);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= mapping_q.size();
        end
    end

endmodule

/* dv/tb_top.sv */
// Testbench top of the RAID stripe address mapper: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY = 3 * 48 + 2;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          calm;

    raid_stripe_address_mapper_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    rsam_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at random, except in calm stretches
    always @(negedge clk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_layout(input rsam_pkg::raid_level_t lvl, input logic [15:0] cs,
                              input logic [3:0] n);
        write_reg(rsam_pkg::CFG_RAID_LEVEL, 16'(lvl));
        write_reg(rsam_pkg::CFG_CHUNK_LEN, cs);
        write_reg(rsam_pkg::CFG_DATA_DISKS, 16'(n));
    endtask

    // Present one sector, with a random gap first, and hold until accepted
    task automatic send_sector(input logic [47:0] sect);
        while (!calm && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sect;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending and wait until every transaction has come out
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [47:0] rand_sector();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case ($urandom_range(3))
            0: v = v & 48'hFFFF;
            1: v = v & 48'hFFFFFFF;
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        rsam_pkg::raid_level_t lvl;
        logic [15:0] cs;
        logic [3:0]  n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        calm = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset layout, then each level with its error cases
        send_sector(48'd0);
        send_sector(48'hFFFF_FFFF_FFFF);
        send_sector(48'd383);
        drain();
        set_layout(rsam_pkg::LVL_MIRROR, 16'd0, 4'd0);
        send_sector(48'hFFFF_FFFF_FFFF);
        drain();
        set_layout(rsam_pkg::LVL_STRIPE, 16'd0, 4'd3);
        send_sector(48'd77);
        drain();
        set_layout(rsam_pkg::LVL_STRIPE, 16'd8, 4'd0);
        send_sector(48'd77);
        drain();
        set_layout(rsam_pkg::LVL_PARITY, 16'd1, 4'd15);
        send_sector(48'd99);
        drain();
        set_layout(rsam_pkg::LVL_PARITY, 16'hFFFF, 4'd14);
        send_sector(48'hFFFF_FFFF_FFFF);
        send_sector(48'd1234567);
        drain();
        set_layout(rsam_pkg::LVL_PARITY, 16'd1, 4'd1);
        for (int i = 0; i < 4; i++)
            send_sector(48'(i));
        drain();
        set_layout(rsam_pkg::LVL_PAIRS, 16'd4, 4'd1);
        send_sector(48'd50);
        drain();
        set_layout(rsam_pkg::LVL_PAIRS, 16'd4, 4'd15);
        send_sector(48'd50);
        send_sector(48'hFFFF_FFFF_FFFF);
        drain();

        // Random phases of 60 sectors each under random layouts
        for (int ph = 0; ph < 15; ph++)
        begin
            lvl = rsam_pkg::raid_level_t'($urandom_range(3));
            case ($urandom_range(4))
                0: cs = 16'hFFFF;
                1: cs = 16'd1;
                2: cs = 16'($urandom);
                default: cs = 16'($urandom_range(64, 1));
            endcase
            if ($urandom_range(9) == 0)
                cs = 16'd0;
            n = 4'($urandom_range(15));
            set_layout(lvl, cs, n);
            calm = (ph == 7);
            for (int i = 0; i < 60; i++)
                send_sector(rand_sector());
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
